FILE: rtl/wmrs_pkg.sv
// Shared types and constants for the windowed mean / RMS / deviation block.
`default_nettype none

package wmrs_pkg;

  // Width of each result field
  localparam int unsigned OUT_W = 16;
  // Result tdata carries mean, rms and std
  localparam int unsigned OUT_TDATA_W = 3 * OUT_W;
  // Register file port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_STOP  = 1'b1;

  // Operations of the shared iterative unit
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  // Post-processing sequence, in execution order
  typedef enum logic [2:0] {
    STEP_MEAN = 3'd0,  // |sum| / n
    STEP_MSQ  = 3'd1,  // sumsq / n
    STEP_RMS  = 3'd2,  // sqrt of mean square
    STEP_P1   = 3'd3,  // n * sumsq
    STEP_P2   = 3'd4,  // |sum| * |sum|, subtract from n * sumsq
    STEP_NN   = 3'd5,  // n * n
    STEP_VAR  = 3'd6,  // numerator / (n * n)
    STEP_STD  = 3'd7   // sqrt of variance
  } step_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  accum;     // sample transfer: count and accumulate
    logic  close;     // sample transfer carries tlast: capture and clear
    logic  start;     // launch the iterative unit for step
    step_e step;
    logic  load_out;  // load the output register
    logic  bad;       // invalid window: zero result, status set
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic win_ok;     // captured window passes the range checks
    logic unit_done;  // iterative unit finished its operation
  } sts_t;

  function automatic step_e step_next(step_e s);
    step_e n;
    n = STEP_MEAN;
    unique case (s)
      STEP_MEAN: n = STEP_MSQ;
      STEP_MSQ:  n = STEP_RMS;
      STEP_RMS:  n = STEP_P1;
      STEP_P1:   n = STEP_P2;
      STEP_P2:   n = STEP_NN;
      STEP_NN:   n = STEP_VAR;
      STEP_VAR:  n = STEP_STD;
      STEP_STD:  n = STEP_MEAN;
      default:   n = STEP_MEAN;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wmrs_iter.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
`default_nettype none

module wmrs_iter #(
  parameter int unsigned UW = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire wmrs_pkg::op_e   op_i,
  input  wire logic [UW-1:0]   a_i,
  input  wire logic [UW-1:0]   b_i,
  output logic                 done_o,
  output logic [UW-1:0]        res_o
);
  import wmrs_pkg::*;

  localparam int unsigned CW = $clog2(UW + 1);
  localparam logic [CW-1:0] MUL_N  = CW'(UW / 2);
  localparam logic [CW-1:0] DIV_N  = CW'(UW);
  localparam logic [CW-1:0] SQRT_N = CW'(UW / 2);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  op_e           op_q, op_d;
  logic [UW-1:0] x_q, x_d;      // multiplicand / dividend-quotient / radicand
  logic [UW-1:0] y_q, y_d;      // multiplier / divisor / root
  logic [UW-1:0] acc_q, acc_d;  // product / remainder

  logic [UW:0]   div_rem;
  logic [UW+1:0] div_diff;
  logic [UW+1:0] sq_rem;
  logic [UW+1:0] sq_trial;
  logic [UW+2:0] sq_diff;
  logic [UW-1:0] mul_sum;
  logic [CW-1:0] iter_n;

  // One step of each operation
  assign div_rem  = {acc_q, x_q[UW-1]};
  assign div_diff = {1'b0, div_rem} - {2'b00, y_q};
  assign sq_rem   = {acc_q, x_q[UW-1:UW-2]};
  assign sq_trial = {y_q, 2'b01};
  assign sq_diff  = {1'b0, sq_rem} - {1'b0, sq_trial};
  assign mul_sum  = acc_q + (y_q[0] ? x_q : '0);

  always_comb begin
    unique case (op_i)
      OP_MUL:  iter_n = MUL_N;
      OP_DIV:  iter_n = DIV_N;
      OP_SQRT: iter_n = SQRT_N;
      default: iter_n = MUL_N;
    endcase
  end

  // Sequence the iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iter_n;
      op_d   = op_i;
      x_d    = a_i;
      y_d    = (op_i == OP_SQRT) ? '0 : b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      unique case (op_q)
        OP_MUL: begin
          acc_d = mul_sum;
          x_d   = {x_q[UW-2:0], 1'b0};
          y_d   = {1'b0, y_q[UW-1:1]};
        end
        OP_DIV: begin
          acc_d = div_diff[UW+1] ? div_rem[UW-1:0] : div_diff[UW-1:0];
          x_d   = {x_q[UW-2:0], ~div_diff[UW+1]};
        end
        OP_SQRT: begin
          acc_d = sq_diff[UW+2] ? sq_rem[UW-1:0] : sq_diff[UW-1:0];
          y_d   = {y_q[UW-2:0], ~sq_diff[UW+2]};
          x_d   = {x_q[UW-3:0], 2'b00};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  // Pick the operand that ends up holding the answer
  always_comb begin
    unique case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_DIV:  res_o = x_q;
      OP_SQRT: res_o = y_q;
      default: res_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/wmrs_dp.sv
// Datapath: sample accumulators, window capture, post-processing and result registers.
`default_nettype none

module wmrs_dp #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wmrs_pkg::cmd_t              cmd_i,
  output wmrs_pkg::sts_t                   sts_o,
  input  wire logic [SAMPLE_BITS-1:0]      sample_i,
  input  wire logic [INDEX_BITS-1:0]       win_start_i,
  input  wire logic [INDEX_BITS-1:0]       win_stop_i,
  output logic [wmrs_pkg::OUT_W-1:0]       mean_o,
  output logic [wmrs_pkg::OUT_W-1:0]       rms_o,
  output logic [wmrs_pkg::OUT_W-1:0]       std_o,
  output logic                             status_o
);
  import wmrs_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned PW = IB + 1;               // position
  localparam int unsigned SW = SB + IB + 1;          // signed running sum
  localparam int unsigned QW = 2 * SB - 1 + IB;      // running sum of squares
  localparam int unsigned UW = 2 * SB + 2 * IB;      // iterative unit width

  // Running state
  logic [PW-1:0]   pos_q, pos_d, pos_inc;
  logic [SW-1:0]   sum_q, sum_d, sum_add;
  logic [QW-1:0]   sq_q, sq_d, sq_add;
  logic            in_win;
  logic [2*SB-1:0] sq_prod;

  // Captured waveform totals
  logic [PW-1:0]   cap_cnt_q;
  logic [SW-1:0]   cap_sum_q;
  logic [QW-1:0]   cap_sq_q;
  logic            cap_neg;
  logic [SW-1:0]   asum;
  logic [IB-1:0]   n_val;

  // Post-processing
  logic            u_start;
  op_e             u_op;
  logic [UW-1:0]   u_a, u_b, u_res;
  logic            u_done;
  step_e           run_step_q;
  logic [UW-1:0]   num_q;
  logic [OUT_W-1:0] mean_q, rms_q, std_q;
  logic [OUT_W-1:0] out_mean_q, out_rms_q, out_std_q;
  logic             out_status_q;

  // Window test and per-sample terms
  assign in_win  = (pos_q >= {1'b0, win_start_i}) && (pos_q < {1'b0, win_stop_i});
  assign pos_inc = (pos_q == {PW{1'b1}}) ? pos_q : pos_q + 1'b1;
  assign sq_prod = $signed(sample_i) * $signed(sample_i);
  assign sum_add = in_win ? sum_q + {{(SW-SB){sample_i[SB-1]}}, sample_i} : sum_q;
  assign sq_add  = in_win ? sq_q + {{(QW-2*SB+1){1'b0}}, sq_prod[2*SB-2:0]} : sq_q;

  // Advance on a sample transfer, clear after the last one
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    if (cmd_i.close) begin
      pos_d = '0;
      sum_d = '0;
      sq_d  = '0;
    end else if (cmd_i.accum) begin
      pos_d = pos_inc;
      sum_d = sum_add;
      sq_d  = sq_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
    end
  end

  // Capture totals including the last sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      cap_cnt_q <= pos_inc;
      cap_sum_q <= sum_add;
      cap_sq_q  <= sq_add;
    end
  end

  assign cap_neg = cap_sum_q[SW-1];
  assign asum    = cap_neg ? (~cap_sum_q + 1'b1) : cap_sum_q;
  assign n_val   = win_stop_i - win_start_i;

  assign sts_o.win_ok = ({1'b0, win_start_i} < cap_cnt_q) &&
                        ({1'b0, win_stop_i} < cap_cnt_q) &&
                        (win_start_i < win_stop_i);
  assign sts_o.unit_done = u_done;

  // Operands for each step
  always_comb begin
    u_op = OP_MUL;
    u_a  = '0;
    u_b  = '0;
    unique case (cmd_i.step)
      STEP_MEAN: begin
        u_op = OP_DIV;
        u_a  = UW'(asum);
        u_b  = UW'(n_val);
      end
      STEP_MSQ: begin
        u_op = OP_DIV;
        u_a  = UW'(cap_sq_q);
        u_b  = UW'(n_val);
      end
      STEP_RMS: begin
        u_op = OP_SQRT;
        u_a  = u_res;
      end
      STEP_P1: begin
        u_op = OP_MUL;
        u_a  = UW'(cap_sq_q);
        u_b  = UW'(n_val);
      end
      STEP_P2: begin
        u_op = OP_MUL;
        u_a  = UW'(asum);
        u_b  = UW'(asum);
      end
      STEP_NN: begin
        u_op = OP_MUL;
        u_a  = UW'(n_val);
        u_b  = UW'(n_val);
      end
      STEP_VAR: begin
        u_op = OP_DIV;
        u_a  = num_q;
        u_b  = u_res;
      end
      STEP_STD: begin
        u_op = OP_SQRT;
        u_a  = u_res;
      end
      default: begin
        u_op = OP_MUL;
      end
    endcase
  end

  assign u_start = cmd_i.start;

  wmrs_iter #(
    .UW(UW)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(u_start),
    .op_i   (u_op),
    .a_i    (u_a),
    .b_i    (u_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // Write back each finished step
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      run_step_q <= cmd_i.step;
    end
    if (u_done) begin
      unique case (run_step_q)
        STEP_MEAN: mean_q <= cap_neg ? (~u_res[OUT_W-1:0] + 1'b1) : u_res[OUT_W-1:0];
        STEP_RMS:  rms_q  <= u_res[OUT_W-1:0];
        STEP_P1:   num_q  <= u_res;
        STEP_P2:   num_q  <= num_q - u_res;
        STEP_STD:  std_q  <= u_res[OUT_W-1:0];
        default:   num_q  <= num_q;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mean_q   <= cmd_i.bad ? '0 : mean_q;
      out_rms_q    <= cmd_i.bad ? '0 : rms_q;
      out_std_q    <= cmd_i.bad ? '0 : std_q;
      out_status_q <= cmd_i.bad;
    end
  end

  assign mean_o   = out_mean_q;
  assign rms_o    = out_rms_q;
  assign std_o    = out_std_q;
  assign status_o = out_status_q;

endmodule

`default_nettype wire

FILE: rtl/wmrs_ctrl.sv
// Controller: sample intake, post-processing sequence and output handshake.
`default_nettype none

module wmrs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_tvalid_i,
  input  wire logic            s_tlast_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  input  wire wmrs_pkg::sts_t  sts_i,
  output wmrs_pkg::cmd_t       cmd_o
);
  import wmrs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;  // take samples
  localparam logic [1:0] ST_CHK  = 2'd1;  // check captured window
  localparam logic [1:0] ST_RUN  = 2'd2;  // post-processing steps
  localparam logic [1:0] ST_OUT  = 2'd3;  // wait for a free output register

  logic [1:0] state_q, state_d;
  step_e      step_q, step_d;
  logic       bad_q, bad_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;
  logic       out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !ovalid_q || m_tready_i;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    bad_d          = bad_q;
    cmd_o          = '0;
    cmd_o.accum    = accept;
    cmd_o.close    = accept && s_tlast_i;
    cmd_o.step     = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_tlast_i) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.win_ok) begin
          cmd_o.start = 1'b1;
          cmd_o.step  = STEP_MEAN;
          step_d      = STEP_MEAN;
          bad_d       = 1'b0;
          state_d     = ST_RUN;
        end else begin
          bad_d   = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_RUN: begin
        if (sts_i.unit_done) begin
          if (step_q == STEP_STD) begin
            state_d = ST_OUT;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.step  = step_next(step_q);
            step_d      = step_next(step_q);
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.bad      = bad_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the downstream transfer
  always_comb begin
    if (cmd_o.load_out) begin
      ovalid_d = 1'b1;
    end else if (m_tready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= STEP_MEAN;
      bad_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      bad_q    <= bad_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign m_tvalid_o = ovalid_q;

endmodule

`default_nettype wire

FILE: rtl/window_mean_rms_std_top.sv
// Top level: windowed mean, RMS and standard deviation of a sample stream.
// Samples are taken one per cycle; s_axis_tready drops after the tlast transfer.
// Results are worked out by one shared bit-serial multiply/divide/square-root unit
// of width UW = 2*(SAMPLE_BITS+INDEX_BITS); an invalid window skips the unit.
// Reset (rst_ni low, asynchronous) clears position, sums, window registers, state and valid.
`default_nettype none

module window_mean_rms_std_top #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // Sample stream
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // sample
  input  wire logic                                    s_axis_tlast,  // last
  // Result stream
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output logic [wmrs_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,  // mean, rms, std
  output logic [0:0]                                   m_axis_tuser,  // status
  // Register port
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [wmrs_pkg::APB_AW-1:0]             paddr,
  input  wire logic [wmrs_pkg::APB_DW-1:0]             pwdata,
  output logic [wmrs_pkg::APB_DW-1:0]                  prdata,
  output logic                                         pready
);
  import wmrs_pkg::*;

  logic [INDEX_BITS-1:0] win_start_q;
  logic [INDEX_BITS-1:0] win_stop_q;
  logic                  cfg_wr;
  cmd_t                  cmd;
  sts_t                  sts;
  logic [OUT_W-1:0]      mean_val, rms_val, std_val;
  logic                  status_val;

  // Register writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_stop_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW_START) begin
        win_start_q <= pwdata[INDEX_BITS-1:0];
      end else begin
        win_stop_q <= pwdata[INDEX_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_STOP) ? APB_DW'(win_stop_q) : APB_DW'(win_start_q);

  wmrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wmrs_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .win_start_i(win_start_q),
    .win_stop_i (win_stop_q),
    .mean_o     (mean_val),
    .rms_o      (rms_val),
    .std_o      (std_val),
    .status_o   (status_val)
  );

  assign m_axis_tdata = {std_val, rms_val, mean_val};
  assign m_axis_tuser = status_val;

endmodule

`default_nettype wire

FILE: rtl/wmrs_checker.sv
// Port-level checks for the top level, attached by bind.
`default_nettype none

module wmrs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             s_axis_tlast,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [wmrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]                       m_axis_tuser
);
  import wmrs_pkg::*;

  // Mid-waveform samples keep the input open
  a_keep_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("input closed after a non-last sample transfer");

  // The last sample closes the input while the result is worked out
  a_close_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after the last sample transfer");

  // An invalid window reports all-zero values
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid window result carries nonzero values");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind window_mean_rms_std_top wmrs_checker u_wmrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

FILE: tb/wmrs_stats_checker.sv
// Checker: predicts window statistics from observed transfers and compares each result.
module wmrs_stats_checker
  import wmrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // sample
  input  logic                   s_axis_tlast,   // last
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // mean, rms, std
  input  logic [0:0]             m_axis_tuser,   // status
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  input  logic [APB_DW-1:0]      prdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] mean;
    logic [15:0] rms;
    logic [15:0] dev;
    logic        bad;
  } window_stats_t;

  // Window registers as last written
  logic [15:0]   win_first;
  logic [15:0]   win_end;
  // Running state of the waveform in progress
  logic [16:0]   wave_pos;
  longint        wave_sum;
  logic [63:0]   wave_sq;
  window_stats_t stats_due[$];
  logic [15:0]   reg_val;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  // Floor of the square root, one result bit at a time from the top
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'd0, r | (32'd1 << b)};
      if (trial * trial <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  // Add a sample to the window sums; on the last sample queue the statistics
  task automatic take_sample(logic signed [15:0] smp, logic last);
    logic [16:0]   seen;
    logic [63:0]   n;
    logic [63:0]   mag_sum;
    logic [63:0]   mean_mag;
    logic [63:0]   spread;
    longint        sq_term;
    window_stats_t res;
    if (wave_pos >= {1'b0, win_first} && wave_pos < {1'b0, win_end}) begin
      sq_term  = longint'(smp) * longint'(smp);
      wave_sum = wave_sum + longint'(smp);
      wave_sq  = wave_sq + sq_term;
    end
    // Saturate the position instead of wrapping
    if (wave_pos != '1) wave_pos++;
    if (last) begin
      seen = wave_pos;
      res  = '{16'd0, 16'd0, 16'd0, 1'b0};
      if (win_first < seen && win_end < seen && win_first < win_end) begin
        n        = 64'(win_end - win_first);
        mag_sum  = (wave_sum < 0) ? 64'(-wave_sum) : 64'(wave_sum);
        mean_mag = mag_sum / n;
        res.mean = (wave_sum < 0) ? 16'(-mean_mag) : 16'(mean_mag);
        res.rms  = 16'(floor_root(wave_sq / n));
        spread   = n * wave_sq - mag_sum * mag_sum;
        res.dev  = 16'(floor_root(spread / (n * n)));
      end else begin
        res.bad = 1'b1;
      end
      stats_due = {stats_due, res};
      wave_pos = '0;
      wave_sum = 0;
      wave_sq  = '0;
    end
  endtask

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Match one result transfer against the oldest prediction
  task automatic check_result(logic [OUT_TDATA_W-1:0] data, logic status);
    window_stats_t want;
    if (stats_due.size() == 0) begin
      $display("%0t: result with none expected: mean %0d rms %0d std %0d status %0b",
               $time, $signed(data[15:0]), data[31:16], data[47:32], status);
      fail_count++;
    end else begin
      want = stats_due.pop_front();
      compare_field("status", int'(want.bad), int'(status));
      compare_field("mean", int'($signed(want.mean)), int'($signed(data[15:0])));
      compare_field("rms", int'(want.rms), int'(data[31:16]));
      compare_field("std", int'(want.dev), int'(data[47:32]));
    end
  endtask

  // Watch all three ports at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_first = '0;
      win_end   = '0;
      wave_pos  = '0;
      wave_sum  = 0;
      wave_sq   = '0;
      stats_due.delete();
      results_owed = 0;
    end else begin
      // The sample sees the registers as they were before this edge
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tlast);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_WINDOW_STOP) win_end = pwdata[15:0];
          else win_first = pwdata[15:0];
        end else begin
          reg_val = (paddr[2] == REG_WINDOW_STOP) ? win_end : win_first;
          if (prdata !== {16'd0, reg_val}) begin
            $display("%0t: register read at %0d expected %0d got %0d",
                     $time, paddr, reg_val, prdata);
            fail_count++;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser[0]);
      results_owed = stats_due.size();
    end
  end

endmodule

FILE: tb/window_mean_rms_std_top_tb.sv
// Testbench top: drives waveforms and window settings into the block and reports the verdict.
module window_mean_rms_std_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmrs_pkg::*;

  localparam int          RANDOM_SAMPLES = 900;
  localparam int          SETTLE_CYCLES  = 370;
  // Full-scale waveform length; the window covers all but the last sample
  localparam int          LONG_WAVE_LEN  = 200;
  localparam logic [15:0] SMP_MAX        = 16'h7fff;
  localparam logic [15:0] SMP_MIN        = 16'h8000;

  typedef enum int {FILL_FULL, FILL_EDGE, FILL_SMALL} fill_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata;   // sample
  logic                   s_axis_tlast;   // last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // mean, rms, std
  logic [0:0]             m_axis_tuser;   // status
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  int                     fail_count;
  int                     results_owed;
  bit                     tx_gaps = 1'b1;
  bit                     rx_gaps = 1'b1;

  window_mean_rms_std_top i_dut (.*);

  wmrs_stats_checker i_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Present one sample after a random gap and hold it until the transfer
  task automatic send_sample(logic [15:0] smp, logic last);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] pick_sample(fill_e fill);
    case (fill)
      FILL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return SMP_MAX;
          1:       return SMP_MIN;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      FILL_SMALL: return 16'(int'($urandom_range(0, 16)) - 8);
      default:    return 16'($urandom());
    endcase
  endfunction

  task automatic send_wave(int len, fill_e fill);
    for (int i = 0; i < len; i++) send_sample(pick_sample(fill), i == len - 1);
  endtask

  // Drop the stream, wait for every owed result, then let the block settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    // Let the checker book the last transfer before reading its count
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register transfer: setup phase, then access phase until pready
  task automatic reg_access(logic sel, logic wr, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(logic [15:0] first, logic [15:0] past);
    quiesce();
    reg_access(REG_WINDOW_START, 1'b1, first);
    reg_access(REG_WINDOW_STOP, 1'b1, past);
    reg_access(REG_WINDOW_START, 1'b0, 16'd0);
    reg_access(REG_WINDOW_STOP, 1'b0, 16'd0);
    bus_idle();
  endtask

  // Result side: stall a random number of cycles once a result shows
  initial begin
    int gap;
    forever begin
      gap = rx_gaps ? $urandom_range(0, 15) : 0;
      if (gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (gap - 1) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Stimulus
  initial begin
    int          sent;
    int          len;
    int          span;
    logic [15:0] win_lo;
    logic [15:0] win_hi;
    fill_e       fill;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset window is empty, so a lone last sample gives an error
    send_sample(16'h1234, 1'b1);
    // Single-position window at the very start
    set_window(16'd0, 16'd1);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(16'h0000, 1'b1);
    // Full-scale negative samples push RMS to 32768
    set_window(16'd0, 16'd4);
    repeat (4) send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    // Mean of minus one half truncates toward zero
    set_window(16'd1, 16'd3);
    send_sample(16'd5, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(16'd9, 1'b1);
    // Start above stop
    set_window(16'd3, 16'd2);
    repeat (3) send_sample(16'h00ff, 1'b0);
    send_sample(16'hff00, 1'b1);
    // Highest start with lowest stop
    set_window(16'hffff, 16'd0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b1);
    // Move the window while a waveform is in progress
    set_window(16'd2, 16'd5);
    send_sample(16'h0100, 1'b0);
    quiesce();
    reg_access(REG_WINDOW_START, 1'b1, 16'd3);
    reg_access(REG_WINDOW_STOP, 1'b1, 16'd6);
    bus_idle();
    for (int i = 0; i < 7; i++) send_sample(16'(i * 1000 - 3000), i == 6);
    // Wide window of full-scale samples, back to back on both sides
    set_window(16'd0, 16'(LONG_WAVE_LEN - 1));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < LONG_WAVE_LEN; i++) send_sample(SMP_MIN, i == LONG_WAVE_LEN - 1);

    // Random phases: mostly valid windows with waveforms long enough to cover them
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          win_lo = 16'($urandom());
          win_hi = 16'($urandom());
        end
        1: begin
          win_lo = 16'($urandom_range(0, 12));
          win_hi = 16'($urandom_range(0, win_lo));
        end
        default: begin
          win_lo = 16'($urandom_range(0, 12));
          win_hi = win_lo + 16'($urandom_range(1, 12));
        end
      endcase
      set_window(win_lo, win_hi);
      span = (win_hi > 16'd20) ? 20 : int'(win_hi);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) != 0) len = span + 1 + $urandom_range(0, 8);
        else len = $urandom_range(1, span + 1);
        case ($urandom_range(0, 5))
          0:       fill = FILL_EDGE;
          1:       fill = FILL_SMALL;
          default: fill = FILL_FULL;
        endcase
        send_wave(len, fill);
        sent += len;
      end
    end

    quiesce();
    if (fail_count == 0 && results_owed == 0) begin
      $display("window_mean_rms_std_top_tb passed");
    end else begin
      $display("window_mean_rms_std_top_tb failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #25_000_000;
    $display("window_mean_rms_std_top_tb failed");
    $finish;
  end

endmodule
